// File: rtl/core/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam int FRAC_BITS_DEFAULT = 8;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;
  localparam logic [2:0] KIND_I2F = 3'd5;
  localparam logic [2:0] KIND_F2I = 3'd6;

  localparam logic signed [31:0] MAX_S32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN_S32 = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] left_operand;
    logic signed [31:0] right_operand;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               less;
    logic               equal;
    logic               greater;
    logic               fault;
  } out_t;

  // data that rides along the divider stages
  typedef struct packed {
    logic [2:0]  kind;
    logic        neg;
    logic        dz;
    out_t        pre;
    logic [63:0] prod;
  } side_t;

endpackage
`default_nettype wire

// File: rtl/core/fpa_div_stage.sv
`default_nettype none
module fpa_div_stage #(
  parameter int NW = 32 + fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [32:0]   rem_in,
  input  wire logic [NW-1:0] num_in,
  input  wire logic [NW-1:0] quo_in,
  input  wire logic [31:0]   den_in,
  input  wire fpa_pkg::side_t side_in,
  output logic               valid_out,
  output logic [32:0]        rem_out,
  output logic [NW-1:0]      num_out,
  output logic [NW-1:0]      quo_out,
  output logic [31:0]        den_out,
  output fpa_pkg::side_t     side_out
);

  logic [32:0] shifted;
  logic        fits;

  // remainder stays below den, so its low 32 bits hold it
  assign shifted = {rem_in[31:0], num_in[NW-1]};
  assign fits    = shifted >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= fits ? shifted - {1'b0, den_in} : shifted;
      num_out  <= {num_in[NW-2:0], 1'b0};
      quo_out  <= {quo_in[NW-2:0], fits};
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fixed_point_q24_8_alu.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data  (kind, left_operand, right_operand)
// out     | output    | out_valid/out_stall| out_data (value, less, equal, greater, fault)
//
// One operation per cycle while out_stall is low; the restoring divider
// computes one quotient bit per stage over 32 + FRAC_BITS stages.
// rst is synchronous and clears the valid bits of every stage.
// out_stall freezes the whole pipeline while out_valid is high; in_stall is
// high while the last stage holds a result that is stalled.
`default_nettype none
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire fpa_pkg::in_t in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output fpa_pkg::out_t    out_data
);

  localparam int NW = 32 + FRAC_BITS;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input register
  logic         s0_valid;
  fpa_pkg::in_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= in_data;
    end
  end

  // decode stage
  logic signed [31:0]    a, b;
  logic [31:0]           ma, mb;
  logic signed [32:0]    sum, diff;
  logic [31+FRAC_BITS:0] i2f;
  logic                  i2f_ovf;
  fpa_pkg::out_t         pre;

  assign a  = s0.left_operand;
  assign b  = s0.right_operand;
  assign ma = a[31] ? 32'(-a) : 32'(a);
  assign mb = b[31] ? 32'(-b) : 32'(b);
  assign sum  = {a[31], a} + {b[31], b};
  assign diff = {a[31], a} - {b[31], b};
  assign i2f  = {a, {FRAC_BITS{1'b0}}};
  assign i2f_ovf = !((&i2f[31+FRAC_BITS:31]) || !(|i2f[31+FRAC_BITS:31]));

  always_comb begin
    pre = '0;
    case (s0.kind)
      fpa_pkg::KIND_ADD: begin
        if (sum[32] != sum[31]) begin
          pre.value = sum[32] ? fpa_pkg::MIN_S32 : fpa_pkg::MAX_S32;
          pre.fault = 1'b1;
        end else begin
          pre.value = sum[31:0];
        end
      end
      fpa_pkg::KIND_SUB: begin
        if (diff[32] != diff[31]) begin
          pre.value = diff[32] ? fpa_pkg::MIN_S32 : fpa_pkg::MAX_S32;
          pre.fault = 1'b1;
        end else begin
          pre.value = diff[31:0];
        end
      end
      fpa_pkg::KIND_CMP: begin
        pre.less    = a < b;
        pre.equal   = a == b;
        pre.greater = a > b;
      end
      fpa_pkg::KIND_I2F: begin
        if (i2f_ovf) begin
          pre.value = a[31] ? fpa_pkg::MIN_S32 : fpa_pkg::MAX_S32;
          pre.fault = 1'b1;
        end else begin
          pre.value = i2f[31:0];
        end
      end
      fpa_pkg::KIND_F2I: begin
        pre.value = a >>> FRAC_BITS;
      end
      default: begin
        pre = '0;
      end
    endcase
  end

  logic           dv_valid [NW+1];
  logic [32:0]    dv_rem   [NW+1];
  logic [NW-1:0]  dv_num   [NW+1];
  logic [NW-1:0]  dv_quo   [NW+1];
  logic [31:0]    dv_den   [NW+1];
  fpa_pkg::side_t dv_side  [NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]       <= '0;
      dv_num[0]       <= {ma, {FRAC_BITS{1'b0}}};
      dv_quo[0]       <= '0;
      dv_den[0]       <= mb;
      dv_side[0].kind <= s0.kind;
      dv_side[0].neg  <= a[31] ^ b[31];
      dv_side[0].dz   <= b == 32'sd0;
      dv_side[0].pre  <= pre;
      dv_side[0].prod <= 64'(ma) * 64'(mb);
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_div
    fpa_div_stage #(.NW(NW)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (dv_valid[i]),
      .rem_in    (dv_rem[i]),
      .num_in    (dv_num[i]),
      .quo_in    (dv_quo[i]),
      .den_in    (dv_den[i]),
      .side_in   (dv_side[i]),
      .valid_out (dv_valid[i+1]),
      .rem_out   (dv_rem[i+1]),
      .num_out   (dv_num[i+1]),
      .quo_out   (dv_quo[i+1]),
      .den_out   (dv_den[i+1]),
      .side_out  (dv_side[i+1])
    );
  end

  // rounding and saturation for mul and div
  fpa_pkg::side_t sd;
  logic [63:0]    mul_mag;
  logic [32:0]    den_left;
  logic [NW:0]    div_mag;
  logic [63:0]    mag;
  fpa_pkg::out_t  res;

  assign sd       = dv_side[NW];
  assign mul_mag  = (sd.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign den_left = {1'b0, dv_den[NW]} - dv_rem[NW];
  assign div_mag  = {1'b0, dv_quo[NW]} + (NW+1)'(dv_rem[NW] >= den_left);

  always_comb begin
    res = sd.pre;
    mag = (sd.kind == fpa_pkg::KIND_MUL) ? mul_mag : 64'(div_mag);
    if (sd.kind == fpa_pkg::KIND_MUL || sd.kind == fpa_pkg::KIND_DIV) begin
      res = '0;
      if (sd.kind == fpa_pkg::KIND_DIV && sd.dz) begin
        res.fault = 1'b1;
      end else if (sd.neg) begin
        if (mag > 64'h8000_0000) begin
          res.value = fpa_pkg::MIN_S32;
          res.fault = 1'b1;
        end else begin
          res.value = 32'(-mag[31:0]);
        end
      end else begin
        if (mag > 64'h7fff_ffff) begin
          res.value = fpa_pkg::MAX_S32;
          res.fault = 1'b1;
        end else begin
          res.value = mag[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fpa_checker.sv
`default_nettype none
module fpa_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire fpa_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire fpa_pkg::out_t out_data
);

  // stall upstream only while a result is held back
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow a held result");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transfer changed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.less, out_data.equal, out_data.greater}))
    else $error("more than one compare flag");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.less || out_data.equal || out_data.greater)
      |-> out_data.value == 32'sd0 && !out_data.fault)
    else $error("compare result carries value or fault");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
